FILE: rtl/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: session table types
// Payload structs, operation codes, status codes and the token passed along
// the cell chain.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int KEY_W    = 32;
    localparam int SRV_W    = 6;
    localparam int MASK_W   = 64;
    localparam int CNT_W    = 16;
    localparam int REM_W    = 9;
    localparam int STAT_W   = 2;
    localparam logic [CNT_W-1:0] RESET_TIMEOUT = 16'd30;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  key;
        logic [SRV_W-1:0]  server_index;
        logic [MASK_W-1:0] alive_mask;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SRV_W-1:0]  found_server;
        logic [REM_W-1:0]  removed_count;
    } t_out_item;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [SRV_W-1:0] server;
        logic             free_seen;
        logic [REM_W-1:0] removed;
    } t_token;

endpackage

FILE: rtl/sta_cell.sv
// ----------------------------------------------------------------------------
// sta_cell: one session table entry
// Holds one entry and updates it when the operation token passes, then hands
// the token to the next cell through a register, in the following cycle.
// ----------------------------------------------------------------------------
module sta_cell #(
    parameter int SERVER_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sta_pkg::t_token               i_tok,
    output sta_pkg::t_token               o_tok,
    input  sta_pkg::t_in_item             i_item,
    input  logic [sta_pkg::CNT_W-1:0]     i_reload,
    input  logic                          i_commit
);
    import sta_pkg::*;

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [SRV_W-1:0] r_server, n_server;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_claim, n_claim;
    t_token           r_tok, n_tok;

    logic match, alive;
    t_op  op;

    assign op    = t_op'(i_item.operation);
    assign match = r_valid && (r_key == i_item.key);
    assign alive = ({1'b0, r_server} < (SRV_W+1)'(SERVER_COUNT))
                   && i_item.alive_mask[r_server];

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_server = r_server;
        n_cnt    = r_cnt;
        n_claim  = r_claim;
        n_tok    = i_tok;
        if (i_tok.active) begin
            n_claim = 1'b0;
            unique case (op)
                OP_LOOKUP: begin
                    if (match) begin
                        n_tok.hit    = 1'b1;
                        n_tok.server = r_server;
                        n_cnt        = i_reload;
                    end
                end
                OP_INSERT: begin
                    if (match) begin
                        n_tok.hit = 1'b1;
                    end
                    n_claim         = !r_valid && !i_tok.free_seen;
                    n_tok.free_seen = i_tok.free_seen || !r_valid;
                end
                OP_TICK: begin
                    if (r_valid) begin
                        if (!alive || (r_cnt == '0)) begin
                            n_valid       = 1'b0;
                            n_tok.removed = i_tok.removed + REM_W'(i_tok.removed != '1);
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_commit && r_claim) begin
            n_valid  = 1'b1;
            n_key    = i_item.key;
            n_server = i_item.server_index;
            n_cnt    = i_reload;
            n_claim  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_claim <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_claim <= n_claim;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_server <= n_server;
        r_cnt    <= n_cnt;
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/session_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// session_table_with_aging_top: key to server session table with aging
// Each transfer runs one token down a chain of TABLE_ENTRIES cells, one cell
// per cycle, and the token is registered as it leaves the chain; the next
// item is taken only once the token has left the chain and its result is
// loaded. A lookup hit reloads the countdown, an insert claims the lowest
// free cell and writes it after the pass if the key was not found, and a
// tick ages or removes every valid entry.
// ----------------------------------------------------------------------------
module session_table_with_aging_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int SERVER_COUNT  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sta_pkg::t_in_item          i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output sta_pkg::t_out_item         o_item,
    input  logic                       i_cfg_we,
    input  logic [sta_pkg::CNT_W-1:0]  i_cfg_data
);
    import sta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state     r_state, n_state;
    t_in_item   r_item;
    logic       r_start;
    logic [CNT_W-1:0] r_reload;
    t_token     r_final;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic       commit, load;
    t_op        op;

    t_token w_tok [0:TABLE_ENTRIES];

    assign op = t_op'(r_item.operation);

    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].active    = r_start;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        sta_cell #(
            .SERVER_COUNT(SERVER_COUNT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_item  (r_item),
            .i_reload(r_reload),
            .i_commit(commit)
        );
    end

    assign o_ready = (r_state == S_IDLE);
    assign load    = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign commit  = load && (op == OP_INSERT) && !r_final.hit && r_final.free_seen;

    always_comb begin
        n_out = '0;
        unique case (op)
            OP_LOOKUP: begin
                n_out.status       = r_final.hit ? ST_OK : ST_MISS;
                n_out.found_server = r_final.hit ? r_final.server : '0;
            end
            OP_INSERT: begin
                priority if (r_final.hit) begin
                    n_out.status = ST_DUP;
                end else if (!r_final.free_seen) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.status = ST_OK;
                end
            end
            OP_TICK: begin
                n_out.removed_count = r_final.removed;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RUN;
            S_RUN:  if (w_tok[TABLE_ENTRIES].active) n_state = S_DONE;
            S_DONE: if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_reload    <= RESET_TIMEOUT;
        end else begin
            r_state <= n_state;
            r_start <= i_valid && o_ready;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_reload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
        if (w_tok[TABLE_ENTRIES].active) begin
            r_final <= w_tok[TABLE_ENTRIES];
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: tb/session_table_with_aging_top_test.sv
// ----------------------------------------------------------------------------
// session_table_with_aging_top_test: session table self-checking bench
// Drives lookups, inserts, aging ticks and the unused code through the
// valid/ready input channel and checks every result against a shadow copy of
// the table. Covers duplicate keys, a full table, zero and one-tick timeouts,
// dead servers, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module session_table_with_aging_top_test;
    import sta_pkg::*;

    localparam int TABLE_N     = 256;
    localparam int SERVERS     = 64;
    localparam int KEY_POOL_N  = 48;
    localparam int PHASE_ITEMS = 490;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int REPORT_MAX  = 10;
    localparam logic [MASK_W-1:0] ALL_ALIVE = '1;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    t_in_item         i_item     = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    t_out_item        o_item;
    logic             i_cfg_we   = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_off_left = 0;
    int               cycle_count   = 0;
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];

    class session_scoreboard;
        bit               live      [TABLE_N];
        logic [KEY_W-1:0] keys      [TABLE_N];
        logic [SRV_W-1:0] servers   [TABLE_N];
        logic [CNT_W-1:0] countdown [TABLE_N];
        logic [CNT_W-1:0] reload = RESET_TIMEOUT;
        t_out_item        awaited_replies [$];
        int mismatches, transfers, hits, misses, dups, fulls, expired;

        function int find_slot(logic [KEY_W-1:0] k);
            for (int i = 0; i < TABLE_N; i++)
                if (live[i] && keys[i] == k)
                    return i;
            return -1;
        endfunction

        function void accept_request(t_in_item req);
            t_out_item rsp;
            int slot;
            rsp = '0;
            transfers++;
            case (t_op'(req.operation))
                OP_LOOKUP: begin
                    slot = find_slot(req.key);
                    if (slot < 0) begin
                        rsp.status = ST_MISS;
                        misses++;
                    end else begin
                        countdown[slot] = reload;
                        rsp.found_server = servers[slot];
                        hits++;
                    end
                end
                OP_INSERT: begin
                    if (find_slot(req.key) >= 0) begin
                        rsp.status = ST_DUP;
                        dups++;
                    end else begin
                        slot = -1;
                        for (int i = TABLE_N - 1; i >= 0; i--)
                            if (!live[i])
                                slot = i;
                        if (slot < 0) begin
                            rsp.status = ST_FULL;
                            fulls++;
                        end else begin
                            live[slot]      = 1'b1;
                            keys[slot]      = req.key;
                            servers[slot]   = req.server_index;
                            countdown[slot] = reload;
                        end
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < TABLE_N; i++) begin
                        if (live[i]) begin
                            if (servers[i] >= SERVERS || !req.alive_mask[servers[i]] ||
                                countdown[i] == 0) begin
                                live[i] = 1'b0;
                                expired++;
                                if (rsp.removed_count != '1)
                                    rsp.removed_count = rsp.removed_count + 1'b1;
                            end else begin
                                countdown[i] = countdown[i] - 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            awaited_replies.push_back(rsp);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with none pending: status %0d server %0d removed %0d",
                             got.status, got.found_server, got.removed_count);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.status !== want.status || got.found_server !== want.found_server ||
                got.removed_count !== want.removed_count) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected status %0d server %0d removed %0d, %s %0d %0d %0d",
                             want.status, want.found_server, want.removed_count,
                             "got", got.status, got.found_server, got.removed_count);
            end
        endfunction
    endclass

    session_scoreboard sb = new;

    session_table_with_aging_top #(
        .TABLE_ENTRIES(TABLE_N),
        .SERVER_COUNT (SERVERS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_in_item make_request(t_op op, logic [KEY_W-1:0] key,
                                              logic [SRV_W-1:0] srv,
                                              logic [MASK_W-1:0] mask);
        t_in_item req;
        req.operation    = op;
        req.key          = key;
        req.server_index = srv;
        req.alive_mask   = mask;
        return req;
    endfunction

    function automatic t_in_item draw_request();
        t_in_item req;
        int roll;
        roll = $urandom_range(99);
        req.operation    = roll < 40 ? OP_INSERT : roll < 78 ? OP_LOOKUP :
                           roll < 95 ? OP_TICK : OP_NONE;
        req.key          = ($urandom_range(9) == 0) ? $urandom :
                           key_pool[$urandom_range(KEY_POOL_N - 1)];
        req.server_index = $urandom_range(63);
        case ($urandom_range(9))
            0:       req.alive_mask = '0;
            1:       req.alive_mask = {$urandom, $urandom};
            2:       req.alive_mask = ALL_ALIVE;
            default: req.alive_mask = ALL_ALIVE & ~(64'd1 << $urandom_range(63));
        endcase
        return req;
    endfunction

    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.accept_request(req);
    endtask

    task automatic write_reload(input logic [CNT_W-1:0] value);
        i_valid <= 1'b0;
        while (sb.awaited_replies.size() != 0)
            @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.reload = value;
    endtask

    // result side: checks each transfer, then picks ready for the next edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_reply(o_item);
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] first_key;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset timeout
        send_request(make_request(OP_LOOKUP, 32'h1234_5678, 6'd0, ALL_ALIVE));
        send_request(make_request(OP_INSERT, 32'h0000_0000, 6'd0, '0));
        send_request(make_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63, '0));
        send_request(make_request(OP_INSERT, 32'h0000_0000, 6'd17, '0));
        send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0));
        send_request(make_request(OP_NONE, 32'hFFFF_FFFF, 6'd63, ALL_ALIVE));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, ALL_ALIVE));
        send_request(make_request(OP_TICK, 32'hFFFF_FFFF, 6'd63, ALL_ALIVE >> 1));
        send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0));
        send_request(make_request(OP_LOOKUP, 32'h0000_0000, 6'd63, '0));
        // zero timeout: entry goes at the next tick
        write_reload(16'd0);
        send_request(make_request(OP_INSERT, 32'h0000_0005, 6'd1, '0));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, ALL_ALIVE));
        write_reload(16'd1);
        send_request(make_request(OP_INSERT, 32'h0000_0007, 6'd2, '0));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, ALL_ALIVE));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, ALL_ALIVE));
        send_request(make_request(OP_LOOKUP, 32'h0000_0000, 6'd0, '0));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, '0));

        // fill the table, overflow it, then flush it with a dead mask
        write_reload(16'hFFFF);
        first_key = $urandom;
        send_request(make_request(OP_INSERT, first_key, 6'($urandom_range(63)), '0));
        for (int i = 1; i < TABLE_N + 6; i++)
            send_request(make_request(OP_INSERT, $urandom, 6'($urandom_range(63)),
                                      {$urandom, $urandom}));
        send_request(make_request(OP_INSERT, first_key, 6'd5, '0));
        send_request(make_request(OP_LOOKUP, first_key, 6'd0, '0));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, ALL_ALIVE));
        send_request(make_request(OP_TICK, 32'h0000_0000, 6'd0, '0));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    write_reload(16'd3);
                    send_idle_pct = 34;
                    recv_idle_pct = 53;
                end
                1: begin
                    write_reload(16'($urandom_range(12, 1)));
                    send_idle_pct = 53;
                    recv_idle_pct = 34;
                end
                default: begin
                    write_reload(16'd2);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 100)
                    hold_off_left = 2000;
                send_request(draw_request());
            end
        end

        i_valid <= 1'b0;
        while (sb.awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_N + 8) @(posedge i_clk);

        $display("covered %0d transfers: %0d hits, %0d misses, %0d duplicates, %0d full inserts",
                 sb.transfers, sb.hits, sb.misses, sb.dups, sb.fulls);
        $display("aging ticks removed %0d entries; %0d mismatching results",
                 sb.expired, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
